@@ hdl/m2a_pkg.sv @@
`default_nettype none

package m2a_pkg;

    localparam int ELEMENT_BITS  = 16;
    localparam int FRACTION_BITS = 8;

    localparam int E   = ELEMENT_BITS;
    localparam int F   = FRACTION_BITS;
    // Product of two operands that may carry one extra bit (negated adjugate entries).
    localparam int PW  = 2 * E + 2;
    // Sum of two products.
    localparam int SW  = PW + 1;
    // Signed determinant.
    localparam int DTW = 2 * E + 1;
    // Determinant magnitude.
    localparam int DW  = 2 * E;
    // Dividend magnitude and quotient width.
    localparam int NW  = 2 * E + F;
    // Signed quotient.
    localparam int QW  = NW + 1;
    // Signed dividend before its magnitude is taken.
    localparam int NSW = SW + F;
    // Stages from the input register to the last divider step.
    localparam int NS  = 4 + NW;
    localparam int LANES = 4;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_SCALE = 4'd4,
        OP_TRANS = 4'd5,
        OP_INV   = 4'd6,
        OP_DET   = 4'd7,
        OP_TRACE = 4'd8,
        OP_IDENT = 4'd9
    } op_t;

    typedef struct packed {
        logic [3:0]          opcode;
        logic signed [E-1:0] a_row0_col0;
        logic signed [E-1:0] a_row0_col1;
        logic signed [E-1:0] a_row1_col0;
        logic signed [E-1:0] a_row1_col1;
        logic signed [E-1:0] b_row0_col0;
        logic signed [E-1:0] b_row0_col1;
        logic signed [E-1:0] b_row1_col0;
        logic signed [E-1:0] b_row1_col1;
        logic signed [E-1:0] scale_factor;
    } in_t;

    typedef struct packed {
        logic signed [E-1:0] r_row0_col0;
        logic signed [E-1:0] r_row0_col1;
        logic signed [E-1:0] r_row1_col0;
        logic signed [E-1:0] r_row1_col1;
        logic signed [E-1:0] scalar_out;
        logic                overflow_flag;
        logic                singular_flag;
    } out_t;

    typedef struct packed {
        op_t                 op;
        logic signed [E:0]   x0;
        logic signed [E:0]   y0;
        logic signed [E:0]   x1;
        logic signed [E:0]   y1;
        logic signed [E+1:0] direct;
        logic signed [E:0]   adjv;
    } lane_in_t;

    typedef struct packed {
        logic signed [E-1:0] val;
        logic                ovf;
    } lane_res_t;

    typedef struct packed {
        op_t                 op;
        logic signed [E-1:0] m00;
        logic signed [E-1:0] m01;
        logic signed [E-1:0] m10;
        logic signed [E-1:0] m11;
        logic signed [E:0]   trace;
    } scal_in_t;

    typedef struct packed {
        op_t                  op;
        logic                 sing;
        logic signed [DTW-1:0] sc;
    } scal_res_t;

    localparam logic signed [E+1:0] ONE_Q = (E + 2)'(1 << F);

    // Division by 2^F, truncated toward zero.
    function automatic logic signed [SW-1:0] trunc_f(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] rnd;
        begin
            rnd = SW'((1 << F) - 1);
            if (v < 0) begin
                trunc_f = (v + rnd) >>> F;
            end else begin
                trunc_f = v >>> F;
            end
        end
    endfunction

    // Clamp to the element range; the top bit of the result is the overflow flag.
    function automatic logic [E:0] sat_elem(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] maxv;
        logic signed [QW-1:0] minv;
        begin
            maxv = QW'((64'sd1 <<< (E - 1)) - 64'sd1);
            minv = -QW'(64'sd1 <<< (E - 1));
            if (v > maxv) begin
                sat_elem = {1'b1, maxv[E-1:0]};
            end else if (v < minv) begin
                sat_elem = {1'b1, minv[E-1:0]};
            end else begin
                sat_elem = {1'b0, v[E-1:0]};
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/matrix2x2_alu.sv @@
`default_nettype none

// Two-by-two matrix arithmetic unit on signed Q8.8 elements. It takes one item per
// cycle while the output is not stalled; each item passes through an input register,
// a product stage, a sum stage, a preparation stage and 40 steps of a pipelined
// restoring divider in each of the four element lanes, then the merge register that
// drives the result channel. The divider depth sets the latency for every opcode.
// Each stage moves on whenever its successor is empty or moving, so bubbles close
// up while a result waits to be taken.
module matrix2x2_alu
    import m2a_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic [NS-1:0] v_reg;
    logic          m_valid_reg;
    logic [NS:0]   adv;
    in_t           it_reg;

    logic signed [E-1:0] am [4];
    logic signed [E-1:0] bm [4];
    logic signed [E:0]   adja [4];
    logic signed [E:0]   adjb [4];
    op_t                 op;
    lane_in_t            lin  [LANES];
    lane_res_t           lres [LANES];
    scal_in_t            sin;
    scal_res_t           sres;
    logic signed [DTW-1:0] det;

    always_comb begin
        adv[NS] = !m_valid_reg || m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (adv[NS]) begin
                m_valid_reg <= v_reg[NS-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            it_reg <= s_data;
        end
    end

    always_comb begin
        op    = op_t'(it_reg.opcode);
        am[0] = it_reg.a_row0_col0;
        am[1] = it_reg.a_row0_col1;
        am[2] = it_reg.a_row1_col0;
        am[3] = it_reg.a_row1_col1;
        bm[0] = it_reg.b_row0_col0;
        bm[1] = it_reg.b_row0_col1;
        bm[2] = it_reg.b_row1_col0;
        bm[3] = it_reg.b_row1_col1;
        adja[0] = (E + 1)'(am[3]);
        adja[1] = -(E + 1)'(am[1]);
        adja[2] = -(E + 1)'(am[2]);
        adja[3] = (E + 1)'(am[0]);
        adjb[0] = (E + 1)'(bm[3]);
        adjb[1] = -(E + 1)'(bm[1]);
        adjb[2] = -(E + 1)'(bm[2]);
        adjb[3] = (E + 1)'(bm[0]);

        sin.op    = op;
        sin.m00   = (op == OP_DIV) ? bm[0] : am[0];
        sin.m01   = (op == OP_DIV) ? bm[1] : am[1];
        sin.m10   = (op == OP_DIV) ? bm[2] : am[2];
        sin.m11   = (op == OP_DIV) ? bm[3] : am[3];
        sin.trace = (E + 1)'(am[0]) + (E + 1)'(am[3]);

        for (int l = 0; l < LANES; l++) begin
            lin[l].op     = op;
            lin[l].x0     = '0;
            lin[l].y0     = '0;
            lin[l].x1     = '0;
            lin[l].y1     = '0;
            lin[l].direct = '0;
            lin[l].adjv   = adja[l];
            case (op)
                OP_ADD: begin
                    lin[l].direct = (E + 2)'(am[l]) + (E + 2)'(bm[l]);
                end
                OP_SUB: begin
                    lin[l].direct = (E + 2)'(am[l]) - (E + 2)'(bm[l]);
                end
                OP_MUL: begin
                    lin[l].x0 = (E + 1)'(am[(l / 2) * 2]);
                    lin[l].y0 = (E + 1)'(bm[l % 2]);
                    lin[l].x1 = (E + 1)'(am[(l / 2) * 2 + 1]);
                    lin[l].y1 = (E + 1)'(bm[2 + (l % 2)]);
                end
                OP_DIV: begin
                    lin[l].x0 = (E + 1)'(am[(l / 2) * 2]);
                    lin[l].y0 = adjb[l % 2];
                    lin[l].x1 = (E + 1)'(am[(l / 2) * 2 + 1]);
                    lin[l].y1 = adjb[2 + (l % 2)];
                end
                OP_SCALE: begin
                    lin[l].x0 = (E + 1)'(it_reg.scale_factor);
                    lin[l].y0 = (E + 1)'(am[l]);
                end
                OP_TRANS: begin
                    lin[l].direct = (E + 2)'(am[(l % 2) * 2 + (l / 2)]);
                end
                OP_IDENT: begin
                    lin[l].direct = ((l / 2) == (l % 2)) ? ONE_Q : '0;
                end
                default: begin
                    lin[l].direct = '0;
                end
            endcase
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        m2a_lane u_lane (
            .aclk (aclk),
            .adv  (adv[NS-1:1]),
            .lin  (lin[g]),
            .det  (det),
            .lres (lres[g])
        );
    end

    m2a_scal u_scal (
        .aclk (aclk),
        .adv  (adv[NS-1:1]),
        .sin  (sin),
        .det  (det),
        .sres (sres)
    );

    m2a_merge u_merge (
        .aclk (aclk),
        .adv  (adv[NS]),
        .lres (lres),
        .sres (sres),
        .res  (m_data)
    );

    assign s_ready = adv[0];
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

@@ hdl/m2a_lane.sv @@
`default_nettype none

module m2a_lane
    import m2a_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic [NS-2:0]         adv,
    input  wire lane_in_t              lin,
    input  wire logic signed [DTW-1:0] det,
    output lane_res_t                  lres
);

    op_t                 op1_reg, op2_reg;
    logic signed [PW-1:0] p0_reg, p1_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [E+1:0] dir1_reg, dir2_reg;
    logic signed [E:0]   adj1_reg, adj2_reg;

    // Index 0 is the preparation stage, index k+1 the result of divider step k.
    logic [DW-1:0]        rem_reg [NW+1];
    logic [NW-1:0]        nsh_reg [NW+1];
    logic [NW-1:0]        quo_reg [NW+1];
    logic [DW-1:0]        den_reg [NW+1];
    logic                 neg_reg [NW+1];
    logic                 udiv_reg[NW+1];
    logic signed [SW-1:0] nd_reg  [NW+1];

    logic [DW-1:0]        rem_next[NW+1];
    logic [NW-1:0]        nsh_next[NW+1];
    logic [NW-1:0]        quo_next[NW+1];
    logic [DW-1:0]        den_next0;
    logic                 neg_next0;
    logic                 udiv_next0;
    logic signed [SW-1:0] nd_next0;

    logic signed [NSW-1:0] num;
    logic [NSW-1:0]        num_mag;
    logic signed [DTW-1:0] det_abs;
    logic [DW:0]           trial;
    logic                  ge;
    logic signed [QW-1:0]  qs;
    logic [E:0]            sat;

    // Preparation: pick the dividend and the non-dividing result.
    always_comb begin
        if (op2_reg == OP_INV) begin
            num = NSW'(adj2_reg) <<< (2 * F);
        end else begin
            num = NSW'(sum_reg) <<< F;
        end
        num_mag  = (num < 0) ? NSW'(-num) : NSW'(num);
        det_abs  = (det < 0) ? -det : det;
        den_next0 = det_abs[DW-1:0];
        neg_next0 = (num < 0) != (det < 0);
        udiv_next0 = (op2_reg == OP_INV) || (op2_reg == OP_DIV);
        if ((op2_reg == OP_MUL) || (op2_reg == OP_SCALE)) begin
            nd_next0 = trunc_f(sum_reg);
        end else begin
            nd_next0 = SW'(dir2_reg);
        end
        rem_next[0] = '0;
        nsh_next[0] = num_mag[NW-1:0];
        quo_next[0] = '0;
        trial = '0;
        ge = 1'b0;
        // One restoring step per pipeline stage.
        for (int k = 0; k < NW; k++) begin
            trial = {rem_reg[k], nsh_reg[k][NW-1]};
            ge = trial >= {1'b0, den_reg[k]};
            rem_next[k+1] = ge ? DW'(trial - {1'b0, den_reg[k]}) : trial[DW-1:0];
            nsh_next[k+1] = {nsh_reg[k][NW-2:0], 1'b0};
            quo_next[k+1] = {quo_reg[k][NW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            op1_reg  <= lin.op;
            p0_reg   <= lin.x0 * lin.y0;
            p1_reg   <= lin.x1 * lin.y1;
            dir1_reg <= lin.direct;
            adj1_reg <= lin.adjv;
        end
        if (adv[1]) begin
            op2_reg  <= op1_reg;
            sum_reg  <= SW'(p0_reg) + SW'(p1_reg);
            dir2_reg <= dir1_reg;
            adj2_reg <= adj1_reg;
        end
        if (adv[2]) begin
            rem_reg[0]  <= rem_next[0];
            nsh_reg[0]  <= nsh_next[0];
            quo_reg[0]  <= quo_next[0];
            den_reg[0]  <= den_next0;
            neg_reg[0]  <= neg_next0;
            udiv_reg[0] <= udiv_next0;
            nd_reg[0]   <= nd_next0;
        end
        for (int k = 0; k < NW; k++) begin
            if (adv[3+k]) begin
                rem_reg[k+1]  <= rem_next[k+1];
                nsh_reg[k+1]  <= nsh_next[k+1];
                quo_reg[k+1]  <= quo_next[k+1];
                den_reg[k+1]  <= den_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                udiv_reg[k+1] <= udiv_reg[k];
                nd_reg[k+1]   <= nd_reg[k];
            end
        end
    end

    always_comb begin
        if (udiv_reg[NW]) begin
            qs = neg_reg[NW] ? -$signed({1'b0, quo_reg[NW]}) : $signed({1'b0, quo_reg[NW]});
        end else begin
            qs = QW'(nd_reg[NW]);
        end
        sat = sat_elem(qs);
        lres.val = sat[E-1:0];
        lres.ovf = sat[E];
    end

endmodule

`default_nettype wire

@@ hdl/m2a_scal.sv @@
`default_nettype none

module m2a_scal
    import m2a_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic [NS-2:0]         adv,
    input  wire scal_in_t              sin,
    output logic signed [DTW-1:0]      det,
    output scal_res_t                  sres
);

    op_t                   op1_reg, op2_reg;
    logic signed [DW-1:0]  q0_reg, q1_reg;
    logic signed [DTW-1:0] det_reg;
    logic signed [E:0]     tr1_reg, tr2_reg;

    op_t                   op_reg  [NW+1];
    logic                  sing_reg[NW+1];
    logic signed [DTW-1:0] sc_reg  [NW+1];

    logic                  sing_next;
    logic signed [DTW-1:0] sc_next;
    logic signed [SW-1:0]  det_t;

    always_comb begin
        det_t = trunc_f(SW'(det_reg));
        sing_next = (det_reg == '0) && ((op2_reg == OP_DIV) || (op2_reg == OP_INV));
        if (op2_reg == OP_DET) begin
            sc_next = DTW'(det_t);
        end else if (op2_reg == OP_TRACE) begin
            sc_next = DTW'(tr2_reg);
        end else begin
            sc_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            op1_reg <= sin.op;
            q0_reg  <= sin.m00 * sin.m11;
            q1_reg  <= sin.m01 * sin.m10;
            tr1_reg <= sin.trace;
        end
        if (adv[1]) begin
            op2_reg <= op1_reg;
            det_reg <= DTW'(q0_reg) - DTW'(q1_reg);
            tr2_reg <= tr1_reg;
        end
        if (adv[2]) begin
            op_reg[0]   <= op2_reg;
            sing_reg[0] <= sing_next;
            sc_reg[0]   <= sc_next;
        end
        for (int k = 0; k < NW; k++) begin
            if (adv[3+k]) begin
                op_reg[k+1]   <= op_reg[k];
                sing_reg[k+1] <= sing_reg[k];
                sc_reg[k+1]   <= sc_reg[k];
            end
        end
    end

    assign det       = det_reg;
    assign sres.op   = op_reg[NW];
    assign sres.sing = sing_reg[NW];
    assign sres.sc   = sc_reg[NW];

endmodule

`default_nettype wire

@@ hdl/m2a_merge.sv @@
`default_nettype none

module m2a_merge
    import m2a_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      adv,
    input  wire lane_res_t lres [LANES],
    input  wire scal_res_t sres,
    output out_t           res
);

    out_t       out_reg, out_next;
    logic       is_mat;
    logic       is_scl;
    logic [E:0] ssat;

    always_comb begin
        is_mat = (sres.op == OP_ADD) || (sres.op == OP_SUB) || (sres.op == OP_MUL)
              || (sres.op == OP_DIV) || (sres.op == OP_SCALE) || (sres.op == OP_TRANS)
              || (sres.op == OP_INV) || (sres.op == OP_IDENT);
        is_scl = (sres.op == OP_DET) || (sres.op == OP_TRACE);
        ssat = sat_elem(QW'(sres.sc));
        out_next = '0;
        if (is_mat && sres.sing) begin
            out_next.singular_flag = 1'b1;
        end else if (is_mat) begin
            out_next.r_row0_col0   = lres[0].val;
            out_next.r_row0_col1   = lres[1].val;
            out_next.r_row1_col0   = lres[2].val;
            out_next.r_row1_col1   = lres[3].val;
            out_next.overflow_flag = lres[0].ovf | lres[1].ovf | lres[2].ovf | lres[3].ovf;
        end else if (is_scl) begin
            out_next.scalar_out    = ssat[E-1:0];
            out_next.overflow_flag = ssat[E];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign res = out_reg;

endmodule

`default_nettype wire
